// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion %m failed");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion %m failed");

`endif

// ===== hw/rtl/txr_pkg.sv =====
`timescale 1ns / 1ps
package txr_pkg;

   localparam int RING_DEPTH_DEF  = 4096;
   localparam int CHUNK_LIMIT_DEF = 512;

   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 16;
   localparam int FIDX_W  = 12;
   localparam int START_W = 12;
   localparam int SLEN_W  = 10;
   localparam int SPACE_W = 12;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] data_byte;
      logic              block_first;
      logic              block_last;
      logic [LEN_W-1:0]  block_length;
      logic              link_ready;
      logic              link_busy;
      logic              link_accepts;
      logic [FIDX_W-1:0] fetch_index;
   } txr_req_type;

   typedef struct packed {
      logic               status;
      logic               submit_valid;
      logic [START_W-1:0] submit_start;
      logic [SLEN_W-1:0]  submit_length;
      logic [BYTE_W-1:0]  fetched_byte;
      logic [SPACE_W-1:0] space_left;
   } txr_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RETIRE,
      S_OFFER,
      S_MOD,
      S_DONE
   } txr_state_type;

endpackage

// ===== hw/rtl/txr_if.sv =====
`timescale 1ns / 1ps
interface txr_req_if;
   import txr_pkg::*;
   logic        valid;
   logic        ready;
   txr_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface txr_rsp_if;
   import txr_pkg::*;
   logic        valid;
   logic        ready;
   txr_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/txr_ring_mem.sv =====
`timescale 1ns / 1ps
module txr_ring_mem #(
   parameter int RING_DEPTH = txr_pkg::RING_DEPTH_DEF,
   parameter int IDX_W      = $clog2(RING_DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [txr_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [txr_pkg::BYTE_W-1:0] rd_data
);
   import txr_pkg::*;

   logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/txr_fetch_mod.sv =====
`timescale 1ns / 1ps
module txr_fetch_mod #(
   parameter int RING_DEPTH = txr_pkg::RING_DEPTH_DEF,
   parameter int IDX_W      = $clog2(RING_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [txr_pkg::FIDX_W-1:0] fetch_index,
   output logic                       done,
   output logic [IDX_W-1:0]           ring_index
);
   import txr_pkg::*;

   // Exact reciprocal for any FIDX_W-bit dividend.
   localparam int SHIFT    = FIDX_W + $clog2(RING_DEPTH);
   localparam longint unsigned RECIP =
      ((longint'(1) << SHIFT) + longint'(RING_DEPTH) - 1) / longint'(RING_DEPTH);
   localparam int RECIP_W  = FIDX_W + 2;
   localparam int PROD_W   = (FIDX_W + RECIP_W > SHIFT + 1) ? FIDX_W + RECIP_W : SHIFT + 1;
   localparam int Q_W      = PROD_W - SHIFT;

   logic              v1_ff, v2_ff, v3_ff;
   logic [FIDX_W-1:0] idx1_ff, idx2_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [FIDX_W-1:0] qd_ff;
   logic [IDX_W-1:0]  res_ff;
   logic [Q_W-1:0]    quot;
   logic [PROD_W-1:0] qd_full;
   logic [FIDX_W-1:0] diff;

   assign quot    = Q_W'(prod_ff >> SHIFT);
   assign qd_full = PROD_W'(quot) * PROD_W'(RING_DEPTH);
   assign diff    = idx2_ff - qd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= fetch_index;
      prod_ff <= PROD_W'(fetch_index) * PROD_W'(RECIP);
      idx2_ff <= idx1_ff;
      qd_ff   <= FIDX_W'(qd_full);
      res_ff  <= IDX_W'(diff);
   end

   assign done       = v3_ff;
   assign ring_index = res_ff;

endmodule

// ===== hw/rtl/tx_ring_chunked_submit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload        Transfer
// req_port  in   txr_req_type   valid && ready
// rsp_port  out  txr_rsp_type   valid && ready
//
// One item at a time: a write or unknown op goes from S_EXEC to S_DONE; a
// poll or a closing write also passes S_RETIRE and, when the link is up and
// not busy, S_OFFER; a read passes S_MOD (3-stage reciprocal modulo on
// fetch_index), then the registered ring memory read port.
// Synchronous active-high reset clears indices, in-flight count, block flag
// and handshake state; ring contents stay undefined until written.
// A stalled response holds in its output register; the next request is
// taken while it waits, and a finished item waits in S_DONE for the slot.
module tx_ring_chunked_submit #(
   parameter int RING_DEPTH  = txr_pkg::RING_DEPTH_DEF,
   parameter int CHUNK_LIMIT = txr_pkg::CHUNK_LIMIT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   txr_req_if.sink      req_port,
   txr_rsp_if.source    rsp_port
);
   import txr_pkg::*;

`include "assert_macros.svh"

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int RUN_W = $clog2(CHUNK_LIMIT + 1);
   localparam int SUM_W = ((IDX_W > RUN_W) ? IDX_W : RUN_W) + 1;
   localparam int RC_W  = (CNT_W > RUN_W) ? CNT_W : RUN_W;
   localparam int ADM_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

   txr_state_type    state_ff, state_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [RUN_W-1:0] flight_ff, flight_in;
   logic             admitted_ff, admitted_in;
   txr_req_type      req_ff, req_in;
   logic             status_ff, status_in;
   logic             sub_valid_ff, sub_valid_in;
   logic [IDX_W-1:0] sub_start_ff, sub_start_in;
   logic [RUN_W-1:0] sub_len_ff, sub_len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   txr_rsp_type      rsp_ff, rsp_in;

   logic [CNT_W-1:0] used_cnt;
   logic [CNT_W-1:0] free_cnt;
   logic [CNT_W-1:0] run_raw;
   logic [RUN_W-1:0] run_cap;
   logic [IDX_W-1:0] wr_inc;
   logic [SUM_W-1:0] rd_sum;
   logic [IDX_W-1:0] rd_retired;
   logic             fits;
   logic             admit;

   logic              mem_we;
   logic              mem_re;
   logic [BYTE_W-1:0] mem_rdata;
   logic              fetch_start;
   logic              fetch_done;
   logic [IDX_W-1:0]  fetch_idx;

   txr_ring_mem #(
      .RING_DEPTH (RING_DEPTH),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_ff.data_byte),
      .rd_en   (mem_re),
      .rd_addr (fetch_idx),
      .rd_data (mem_rdata)
   );

   txr_fetch_mod #(
      .RING_DEPTH (RING_DEPTH),
      .IDX_W      (IDX_W)
   ) u_fetch (
      .clock       (clock),
      .reset       (reset),
      .start       (fetch_start),
      .fetch_index (req_ff.fetch_index),
      .done        (fetch_done),
      .ring_index  (fetch_idx)
   );

   // Occupancy, free space and the contiguous run starting at read index.
   assign used_cnt = (wr_idx_ff >= rd_idx_ff) ?
                     CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff) :
                     CNT_W'(RING_DEPTH) - CNT_W'(rd_idx_ff) + CNT_W'(wr_idx_ff);
   assign free_cnt = CNT_W'(RING_DEPTH - 1) - used_cnt;
   assign run_raw  = (wr_idx_ff > rd_idx_ff) ?
                     CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff) :
                     CNT_W'(RING_DEPTH) - CNT_W'(rd_idx_ff);
   assign run_cap  = (RC_W'(run_raw) > RC_W'(CHUNK_LIMIT)) ?
                     RUN_W'(CHUNK_LIMIT) : RUN_W'(run_raw);

   // Advance write index with wrap; retire in-flight bytes from read index.
   assign wr_inc     = (wr_idx_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
   assign rd_sum     = SUM_W'(rd_idx_ff) + SUM_W'(flight_ff);
   assign rd_retired = (rd_sum >= SUM_W'(RING_DEPTH)) ?
                       IDX_W'(rd_sum - SUM_W'(RING_DEPTH)) : IDX_W'(rd_sum);

   // All-or-nothing admission on the opening byte of a block.
   assign fits  = ADM_W'(req_ff.block_length) <= ADM_W'(free_cnt);
   assign admit = req_ff.block_first ? fits : admitted_ff;

   assign req_port.ready   = (state_ff == S_IDLE);
   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      flight_in    = flight_ff;
      admitted_in  = admitted_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      sub_valid_in = sub_valid_ff;
      sub_start_in = sub_start_ff;
      sub_len_in   = sub_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      fetch_start  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // Capture the request and clear the per-item result fields.
            if (req_port.valid) begin
               req_in       = req_port.payload;
               status_in    = 1'b0;
               sub_valid_in = 1'b0;
               sub_start_in = '0;
               sub_len_in   = '0;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (req_ff.operation)
               OP_WRITE: begin
                  state_in = S_DONE;
                  if (admit) begin
                     // Store unless the ring is full; the block stays open until its last byte.
                     if (wr_inc != rd_idx_ff) begin
                        mem_we    = 1'b1;
                        wr_idx_in = wr_inc;
                     end else begin
                        status_in = 1'b1;
                     end
                     if (req_ff.block_last) begin
                        admitted_in = 1'b0;
                        state_in    = S_RETIRE;
                     end else begin
                        admitted_in = 1'b1;
                     end
                  end else begin
                     // Drop: block rejected or no block open.
                     admitted_in = 1'b0;
                     status_in   = 1'b1;
                  end
               end
               OP_POLL: begin
                  state_in = S_RETIRE;
               end
               OP_READ: begin
                  fetch_start = 1'b1;
                  state_in    = S_MOD;
               end
               OP_NONE: begin
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RETIRE: begin
            // Link idle and set up: retire the chunk in flight, then offer.
            if (req_ff.link_ready && !req_ff.link_busy) begin
               if (flight_ff != '0) begin
                  rd_idx_in = rd_retired;
                  flight_in = '0;
               end
               state_in = S_OFFER;
            end else begin
               state_in = S_DONE;
            end
         end
         S_OFFER: begin
            if (used_cnt != '0) begin
               sub_valid_in = 1'b1;
               sub_start_in = rd_idx_ff;
               sub_len_in   = run_cap;
               if (req_ff.link_accepts) begin
                  flight_in = run_cap;
               end
            end
            state_in = S_DONE;
         end
         S_MOD: begin
            // Issue the ring read once the wrapped index is ready.
            if (fetch_done) begin
               mem_re   = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the output register is free, then load it.
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.status        = status_ff;
               rsp_in.submit_valid  = sub_valid_ff;
               rsp_in.submit_start  = START_W'(sub_start_ff);
               rsp_in.submit_length = SLEN_W'(sub_len_ff);
               rsp_in.fetched_byte  = (req_ff.operation == OP_READ) ? mem_rdata : '0;
               rsp_in.space_left    = SPACE_W'(free_cnt);
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         flight_ff    <= '0;
         admitted_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         flight_ff    <= flight_in;
         admitted_ff  <= admitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      status_ff    <= status_in;
      sub_valid_ff <= sub_valid_in;
      sub_start_ff <= sub_start_in;
      sub_len_ff   <= sub_len_in;
      rsp_ff       <= rsp_in;
   end

   `ASSERT_ALWAYS(a_flight_cap, clock, reset, flight_ff <= RUN_W'(CHUNK_LIMIT))
   `ASSERT_ALWAYS(a_flight_stored, clock, reset, RC_W'(flight_ff) <= RC_W'(used_cnt))
   `ASSERT_ALWAYS(a_wr_idx_range, clock, reset, (IDX_W+1)'(wr_idx_ff) < (IDX_W+1)'(RING_DEPTH))
   `ASSERT_ALWAYS(a_rd_idx_range, clock, reset, (IDX_W+1)'(rd_idx_ff) < (IDX_W+1)'(RING_DEPTH))
   `ASSERT_IMPL(a_fetch_waiting, clock, reset, fetch_done, state_ff == S_MOD)
   `ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import txr_pkg::*;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 12;
   localparam int DEPTH        = RING_DEPTH_DEF;
   localparam int CHUNK        = CHUNK_LIMIT_DEF;
   // Longest stretch with no transfer on either channel before the run is
   // declared hung; covers the receiver hold-off with a wide margin.
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 192;
   localparam int SETTLE_CYCLES = 24;

   // Transmit ring predictor: mirrors the ring, its indices and the open
   // block flag, and queues the result each accepted request must produce.
   class tx_ring_predictor;
      logic [BYTE_W-1:0]  ring_mem [DEPTH];
      bit                 written [DEPTH];
      logic [START_W-1:0] wr_ptr;
      logic [START_W-1:0] rd_ptr;
      logic [SLEN_W-1:0]  flight_len;
      bit                 block_open;
      txr_rsp_type        awaited_rsp [$];
      int unsigned        mismatches;

      function new();
         wr_ptr     = '0;
         rd_ptr     = '0;
         flight_len = '0;
         block_open = 1'b0;
         mismatches = 0;
      endfunction

      function int unsigned stored();
         logic [START_W-1:0] diff;
         diff = wr_ptr - rd_ptr;
         return 32'(diff);
      endfunction

      // One slot always stays empty.
      function int unsigned room();
         return DEPTH - 1 - stored();
      endfunction

      // Retire the chunk in flight, then offer the next contiguous run.
      function void poll_link(logic ready, logic busy, logic accepts,
                              inout txr_rsp_type r);
         int unsigned run;
         if (!ready || busy) return;
         if (flight_len != 0) begin
            rd_ptr     = rd_ptr + flight_len;
            flight_len = '0;
         end
         if (stored() == 0) return;
         if (wr_ptr > rd_ptr) run = 32'(wr_ptr - rd_ptr);
         else run = DEPTH - 32'(rd_ptr);
         if (run > CHUNK) run = CHUNK;
         r.submit_valid  = 1'b1;
         r.submit_start  = rd_ptr;
         r.submit_length = SLEN_W'(run);
         if (accepts) flight_len = SLEN_W'(run);
      endfunction

      function void note_transfer(txr_req_type item);
         txr_rsp_type        r;
         logic [START_W-1:0] next_wr;
         r = '0;
         case (item.operation)
            OP_WRITE: begin
               if (item.block_first) block_open = (item.block_length <= room());
               if (block_open) begin
                  next_wr = wr_ptr + 1'b1;
                  if (next_wr != rd_ptr) begin
                     ring_mem[wr_ptr] = item.data_byte;
                     written[wr_ptr]  = 1'b1;
                     wr_ptr           = next_wr;
                  end else begin
                     r.status = 1'b1;
                  end
                  if (item.block_last) begin
                     block_open = 1'b0;
                     poll_link(item.link_ready, item.link_busy, item.link_accepts, r);
                  end
               end else begin
                  r.status = 1'b1;
               end
            end
            OP_POLL: begin
               poll_link(item.link_ready, item.link_busy, item.link_accepts, r);
            end
            OP_READ: begin
               r.fetched_byte = ring_mem[item.fetch_index];
            end
            default: begin
            end
         endcase
         r.space_left = SPACE_W'(room());
         awaited_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_rsp(txr_rsp_type got);
         txr_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("submit_valid", 32'(want.submit_valid), 32'(got.submit_valid));
         compare_field("submit_start", 32'(want.submit_start), 32'(got.submit_start));
         compare_field("submit_length", 32'(want.submit_length), 32'(got.submit_length));
         compare_field("fetched_byte", 32'(want.fetched_byte), 32'(got.fetched_byte));
         compare_field("space_left", 32'(want.space_left), 32'(got.space_left));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   txr_req_if req_port ();
   txr_rsp_if rsp_port ();

   tx_ring_chunked_submit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

   tx_ring_predictor ring_pred;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_left;
   int unsigned items_sent;
   int unsigned quiet_cycles;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic txr_req_type make_req(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
         logic first, logic last, logic [LEN_W-1:0] len, logic ready, logic busy,
         logic accepts, logic [FIDX_W-1:0] fidx);
      txr_req_type item;
      item.operation    = op;
      item.data_byte    = data;
      item.block_first  = first;
      item.block_last   = last;
      item.block_length = len;
      item.link_ready   = ready;
      item.link_busy    = busy;
      item.link_accepts = accepts;
      item.fetch_index  = fidx;
      return item;
   endfunction

   // Mostly ready, sometimes busy, usually accepting.
   function automatic txr_req_type random_req(logic [OP_W-1:0] op);
      return make_req(op, BYTE_W'($urandom), 1'($urandom), 1'($urandom), LEN_W'($urandom),
                      $urandom_range(99) < 85, $urandom_range(99) < 25,
                      $urandom_range(99) < 75, FIDX_W'($urandom));
   endfunction

   // Read only written slots where any exist: scan up from a random
   // position to the next written one, else fall back to index 0.
   function automatic logic [FIDX_W-1:0] pick_written();
      logic [FIDX_W-1:0] idx;
      idx = FIDX_W'($urandom);
      for (int i = 0; i < DEPTH; i++) begin
         if (ring_pred.written[idx]) return idx;
         idx = idx + 1'b1;
      end
      return '0;
   endfunction

   function automatic txr_req_type read_req();
      txr_req_type item;
      item = random_req(OP_READ);
      item.fetch_index = pick_written();
      return item;
   endfunction

   // Offer one request and hold it until the transfer; called and returns
   // at a falling edge.
   task automatic send(txr_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_port.valid <= 1'b0;
         @(negedge clock);
      end
      req_port.valid   <= 1'b1;
      req_port.payload <= item;
      @(posedge clock);
      while (!req_port.ready) @(posedge clock);
      ring_pred.note_transfer(item);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every queued result has come back.
   task automatic wait_for_results();
      req_port.valid <= 1'b0;
      while (ring_pred.awaited_rsp.size() != 0) @(negedge clock);
   endtask

   // Send one block whose length is capped at budget bytes, well formed unless
   // broken is set; a broken block may close early, run long, never close or
   // be sized to reject.
   task automatic send_block(bit broken, int unsigned budget);
      int unsigned      len;
      int unsigned      count;
      int unsigned      last_at;
      int unsigned      pick;
      logic [LEN_W-1:0] declared;
      txr_req_type      item;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 16);
      else if (pick < 95) len = $urandom_range(17, 200);
      else len = $urandom_range(201, 900);
      if (len > budget) len = budget;
      declared = LEN_W'(len);
      count    = len;
      last_at  = len - 1;
      if (broken) begin
         count   = $urandom_range(1, len + 3);
         last_at = $urandom_range(1) ? $urandom_range(0, count - 1) : count;
         if ($urandom_range(3) == 0)
            declared = LEN_W'($urandom_range(ring_pred.room() + 1, 65535));
      end
      for (int i = 0; i < count; i++) begin
         item = random_req(OP_WRITE);
         item.block_first = (i == 0);
         item.block_last  = (i == last_at);
         if (i == 0) item.block_length = declared;
         send(item);
         // Slip a poll or a read in between bytes now and then.
         if (i + 1 < count && $urandom_range(99) < 8)
            send($urandom_range(1) ? random_req(OP_POLL) : read_req());
      end
   endtask

   task automatic run_random(int unsigned target);
      int unsigned stop_at;
      int unsigned kind;
      txr_req_type item;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            send_block(1'b0, stop_at - items_sent);
         end else if (kind < 62) begin
            send_block(1'b1, stop_at - items_sent);
         end else if (kind < 80) begin
            send(random_req(OP_POLL));
         end else if (kind < 90) begin
            send(read_req());
         end else if (kind < 95) begin
            // Stray byte: dropped unless a broken block was left open.
            item = random_req(OP_WRITE);
            item.block_first = 1'b0;
            send(item);
         end else begin
            send(random_req(OP_NONE));
         end
      end
   endtask

   task automatic run_directed();
      // Poll an empty ring: nothing to offer.
      send(make_req(OP_POLL, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, '0));
      // Unknown operation with every field high: no effect.
      send(make_req(OP_NONE, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, '1));
      // Byte with no block open: dropped.
      send(make_req(OP_WRITE, 8'hFF, 1'b0, 1'b0, 16'h1234, 1'b1, 1'b0, 1'b1, '0));
      // Block far larger than the ring: rejected, and so is its last byte.
      send(make_req(OP_WRITE, 8'h00, 1'b1, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1, '0));
      send(make_req(OP_WRITE, 8'h11, 1'b0, 1'b1, 16'h0001, 1'b1, 1'b0, 1'b1, '0));
      // Zero-length block is admitted; its closing poll finds the link down.
      send(make_req(OP_WRITE, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, '0));
      send(make_req(OP_WRITE, 8'hFF, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, '0));
      // Three-byte block closing while the link is busy.
      send(make_req(OP_WRITE, 8'hA5, 1'b1, 1'b0, 16'h0003, 1'b1, 1'b0, 1'b1, '0));
      send(make_req(OP_WRITE, 8'h5A, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, '0));
      send(make_req(OP_WRITE, 8'h3C, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, '0));
      // Offer refused, then offer taken into flight.
      send(make_req(OP_POLL, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, '0));
      send(make_req(OP_POLL, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, '0));
      send(make_req(OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, 12'd0));
      send(make_req(OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, 12'd4));
      // Busy link holds the chunk in flight; the next poll retires it.
      send(make_req(OP_POLL, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, '0));
      send(make_req(OP_POLL, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, '0));
      // Single-byte block that opens and closes at once.
      send(make_req(OP_WRITE, 8'h77, 1'b1, 1'b1, 16'h0001, 1'b1, 1'b0, 1'b1, '0));
      send(make_req(OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, 12'd5));
      send(make_req(OP_POLL, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1, '0));
   endtask

   // Open a block declared at exactly the free space and close it after a
   // little more than one chunk while the link is busy, so the next poll
   // offers a capped chunk. Then try a block one byte larger than the free
   // space, read back, and drain the ring chunk by chunk.
   task automatic fit_and_cap();
      int unsigned n;
      int unsigned count;
      n     = ring_pred.room();
      count = CHUNK + 8;
      for (int i = 0; i < count; i++)
         send(make_req(OP_WRITE, BYTE_W'($urandom), i == 0, i == count - 1,
                       (i == 0) ? LEN_W'(n) : LEN_W'($urandom), 1'b1, 1'b1, 1'b1,
                       FIDX_W'($urandom)));
      n = ring_pred.room();
      send(make_req(OP_WRITE, BYTE_W'($urandom), 1'b1, 1'b0, LEN_W'(n + 1), 1'b1, 1'b0,
                    1'b1, FIDX_W'($urandom)));
      send(make_req(OP_WRITE, BYTE_W'($urandom), 1'b0, 1'b1, LEN_W'($urandom), 1'b1, 1'b0,
                    1'b1, FIDX_W'($urandom)));
      repeat (20) send(read_req());
      while (ring_pred.stored() != 0 || ring_pred.flight_len != 0)
         send(make_req(OP_POLL, BYTE_W'($urandom), 1'b0, 1'b0, LEN_W'($urandom), 1'b1,
                       1'b0, 1'b1, FIDX_W'($urandom)));
   endtask

   // Receiver: drop ready at random, or hold it low through a requested
   // hold-off, counting the cycles here.
   initial begin
      rsp_port.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_port.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_port.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check every result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_port.valid && rsp_port.ready)
         ring_pred.check_rsp(rsp_port.payload);
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_port.valid && req_port.ready) || (rsp_port.valid && rsp_port.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      ring_pred       = new();
      req_port.valid  = 1'b0;
      req_port.payload = '0;
      send_idle_pct   = 13;
      recv_idle_pct   = 74;
      hold_left       = 0;
      items_sent      = 0;
      quiet_cycles    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: sender mostly busy, receiver mostly stalled.
      run_directed();
      run_random(PHASE_ITEMS / 2);
      // Hold the receiver off while requests keep coming, so the input stalls.
      hold_left = HOLD_CYCLES;
      run_random(PHASE_ITEMS / 2);
      wait_for_results();

      // Phase two: roles swapped; probe admission and the chunk cap first.
      send_idle_pct = 74;
      recv_idle_pct = 13;
      fit_and_cap();
      run_random(PHASE_ITEMS);
      wait_for_results();

      // Phase three: both sides at full rate.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_ITEMS);
      wait_for_results();

      // Let any stray result show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ring_pred.mismatches == 0 && ring_pred.awaited_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
